// File: rtl/core/hcbd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hcbd_pkg
// Shared types and constants for the chunked body decoder: the parser
// phases, the result and error codes, the field widths and the reset values.
// ----------------------------------------------------------------------------
package hcbd_pkg;

    localparam int LENGTH_BITS_DEFAULT = 24;

    localparam int BYTE_W   = 8;
    localparam int KIND_W   = 2;
    localparam int ERR_W    = 2;
    localparam int LENGTH_W = 24;
    localparam int LIMIT_W  = 24;

    localparam logic [LIMIT_W-1:0] BODY_LIMIT_RESET = 24'd65536;

    localparam logic [BYTE_W-1:0] CHAR_LF    = 8'h0A;
    localparam logic [BYTE_W-1:0] CHAR_CR    = 8'h0D;
    localparam logic [BYTE_W-1:0] CHAR_TAB   = 8'h09;
    localparam logic [BYTE_W-1:0] CHAR_VT    = 8'h0B;
    localparam logic [BYTE_W-1:0] CHAR_FF    = 8'h0C;
    localparam logic [BYTE_W-1:0] CHAR_SPACE = 8'h20;
    localparam logic [BYTE_W-1:0] CHAR_PLUS  = 8'h2B;
    localparam logic [BYTE_W-1:0] CHAR_MINUS = 8'h2D;
    localparam logic [BYTE_W-1:0] CHAR_X_LO  = 8'h78;
    localparam logic [BYTE_W-1:0] CHAR_X_UP  = 8'h58;

    typedef enum logic [KIND_W-1:0] {
        KIND_PAYLOAD  = 2'd0,
        KIND_COMPLETE = 2'd1,
        KIND_ERROR    = 2'd2
    } kind_t;

    typedef enum logic [ERR_W-1:0] {
        ERR_NONE     = 2'd0,
        ERR_NEGATIVE = 2'd1,
        ERR_TOO_BIG  = 2'd2
    } error_code_t;

    typedef enum logic [3:0] {
        PH_IDLE    = 4'd0,
        PH_BLANK   = 4'd1,
        PH_SIGN    = 4'd2,
        PH_ZERO    = 4'd3,
        PH_DIGITS  = 4'd4,
        PH_REST    = 4'd5,
        PH_DATA    = 4'd6,
        PH_CRLF    = 4'd7,
        PH_TRAILER = 4'd8,
        PH_DONE    = 4'd9,
        PH_ERROR   = 4'd10
    } phase_t;

    localparam logic [1:0] TLEN_EMPTY = 2'd0;
    localparam logic [1:0] TLEN_CR    = 2'd1;
    localparam logic [1:0] TLEN_LONG  = 2'd2;

endpackage

// File: rtl/core/hcbd_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hcbd_if
// Valid/ready channels of the chunked body decoder: raw body bytes in,
// decoded results out.
// ----------------------------------------------------------------------------
interface hcbd_in_if;
    logic                          valid;
    logic                          ready;
    logic [hcbd_pkg::BYTE_W-1:0]   data_byte;
    logic                          first_byte;

    modport source (output valid, output data_byte, output first_byte, input ready);
    modport sink   (input valid, input data_byte, input first_byte, output ready);
endinterface

interface hcbd_out_if;
    logic                          valid;
    logic                          ready;
    logic [hcbd_pkg::KIND_W-1:0]   kind;
    logic [hcbd_pkg::BYTE_W-1:0]   payload_byte;
    logic [hcbd_pkg::LENGTH_W-1:0] decoded_len;
    logic [hcbd_pkg::ERR_W-1:0]    error_code;

    modport source (output valid, output kind, output payload_byte,
                    output decoded_len, output error_code, input ready);
    modport sink   (input valid, input kind, input payload_byte,
                    input decoded_len, input error_code, output ready);
endinterface

// File: rtl/core/http_chunked_body_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// http_chunked_body_decoder
// Decodes a chunked request body one byte per transfer and passes on the
// payload bytes, a completion result or an error result.
// ----------------------------------------------------------------------------
// The block takes one body byte in every clock cycle while the output side
// takes results. A byte that causes a result is held in an input register,
// goes through the size-line and chunk parser, and its result lands in the
// output register. The parser state is updated once per byte, so the
// sustained rate is one byte per cycle for as long as the output side takes
// results. While a result waits in the output register, one more byte is
// still accepted into the input register; only then does the input side
// stall. The user must write the body limit through cfg_write_en and
// cfg_write_data only while no body is in flight; the block does not check.
// ----------------------------------------------------------------------------
module http_chunked_body_decoder #(
    parameter int LENGTH_BITS = hcbd_pkg::LENGTH_BITS_DEFAULT
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_write_en,
    input  logic [hcbd_pkg::LIMIT_W-1:0] cfg_write_data,
    hcbd_in_if.sink                      in_chan,
    hcbd_out_if.source                   out_chan
);

    localparam int SIZE_W = LENGTH_BITS + 1;
    localparam int SUM_W  = LENGTH_BITS + 2;
    localparam int WIDE_W = LENGTH_BITS + 5;

    // Configuration.
    logic [hcbd_pkg::LIMIT_W-1:0] body_limit_reg;

    // Input register.
    logic                          in_valid_reg;
    logic [hcbd_pkg::BYTE_W-1:0]   data_reg;
    logic                          first_reg;

    // Parser state.
    hcbd_pkg::phase_t              phase_reg, phase_next;
    logic [SIZE_W-1:0]             chunk_reg, chunk_next;
    logic [SIZE_W-1:0]             left_reg, left_next;
    logic [LENGTH_BITS-1:0]        count_reg, count_next;
    logic                          neg_reg, neg_next;
    logic [1:0]                    tlen_reg, tlen_next;

    // Result register.
    logic                          res_valid_reg;
    hcbd_pkg::kind_t               kind_reg;
    logic [hcbd_pkg::BYTE_W-1:0]   payload_reg;
    logic [hcbd_pkg::LENGTH_W-1:0] length_reg;
    hcbd_pkg::error_code_t         code_reg;

    logic                          advance;
    logic                          emit;
    hcbd_pkg::kind_t               emit_kind;
    hcbd_pkg::error_code_t         emit_code;
    logic [hcbd_pkg::BYTE_W-1:0]   emit_byte;

    // A first byte clears the body state before the byte itself is parsed.
    hcbd_pkg::phase_t              cur_phase;
    logic [SIZE_W-1:0]             cur_chunk;
    logic [SIZE_W-1:0]             cur_left;
    logic [LENGTH_BITS-1:0]        cur_count;
    logic                          cur_neg;
    logic [1:0]                    cur_tlen;

    logic [hcbd_pkg::BYTE_W-1:0]   c;
    logic                          hex_ok;
    logic [3:0]                    hex_digit;
    logic                          is_blank;
    logic                          is_lf;
    logic                          is_x;
    logic [WIDE_W-1:0]             shifted;
    logic [SIZE_W-1:0]             chunk_added;
    logic [LENGTH_BITS-1:0]        limit;
    logic [SUM_W-1:0]              total;
    logic                          neg_error;
    logic                          size_zero;
    logic                          over_limit;
    logic                          in_size_line;
    logic [SIZE_W-1:0]             left_dec;

    assign advance         = in_valid_reg && (!res_valid_reg || out_chan.ready);
    assign in_chan.ready   = !in_valid_reg || advance;

    assign cur_phase = first_reg ? hcbd_pkg::PH_BLANK : phase_reg;
    assign cur_chunk = first_reg ? '0 : chunk_reg;
    assign cur_left  = first_reg ? '0 : left_reg;
    assign cur_count = first_reg ? '0 : count_reg;
    assign cur_neg   = first_reg ? 1'b0 : neg_reg;
    assign cur_tlen  = first_reg ? hcbd_pkg::TLEN_EMPTY : tlen_reg;

    assign c = data_reg;

    always_comb
    begin
        hex_ok    = 1'b1;
        hex_digit = 4'd0;
        if (c >= 8'h30 && c <= 8'h39)
        begin
            hex_digit = 4'(c - 8'h30);
        end
        else if (c >= 8'h61 && c <= 8'h66)
        begin
            hex_digit = 4'(c - 8'h57);
        end
        else if (c >= 8'h41 && c <= 8'h46)
        begin
            hex_digit = 4'(c - 8'h37);
        end
        else
        begin
            hex_ok = 1'b0;
        end
    end

    assign is_blank = (c == hcbd_pkg::CHAR_SPACE) || (c == hcbd_pkg::CHAR_TAB) ||
                      (c == hcbd_pkg::CHAR_VT) || (c == hcbd_pkg::CHAR_FF) ||
                      (c == hcbd_pkg::CHAR_CR);
    assign is_lf    = (c == hcbd_pkg::CHAR_LF);
    assign is_x     = (c == hcbd_pkg::CHAR_X_LO) || (c == hcbd_pkg::CHAR_X_UP);

    // Appending a digit is a shift by four; anything that reaches past the
    // size field saturates, which always fails the limit check.
    assign shifted     = {cur_chunk, hex_digit};
    assign chunk_added = (shifted[WIDE_W-1:SIZE_W] != '0) ? '1 : shifted[SIZE_W-1:0];

    assign limit      = LENGTH_BITS'(body_limit_reg);
    assign total      = SUM_W'(cur_count) + SUM_W'(cur_chunk);
    assign size_zero  = (cur_chunk == '0);
    assign neg_error  = cur_neg && !size_zero;
    assign over_limit = total > SUM_W'(limit);
    assign left_dec   = cur_left - SIZE_W'(1);

    assign in_size_line = (cur_phase == hcbd_pkg::PH_BLANK) ||
                          (cur_phase == hcbd_pkg::PH_SIGN) ||
                          (cur_phase == hcbd_pkg::PH_ZERO) ||
                          (cur_phase == hcbd_pkg::PH_DIGITS) ||
                          (cur_phase == hcbd_pkg::PH_REST);

    // Next parser state.
    always_comb
    begin
        phase_next = cur_phase;
        chunk_next = cur_chunk;
        left_next  = cur_left;
        count_next = cur_count;
        neg_next   = cur_neg;
        tlen_next  = cur_tlen;
        if (in_size_line && is_lf)
        begin
            if (neg_error)
            begin
                phase_next = hcbd_pkg::PH_ERROR;
            end
            else if (size_zero)
            begin
                phase_next = hcbd_pkg::PH_TRAILER;
                tlen_next  = hcbd_pkg::TLEN_EMPTY;
            end
            else if (over_limit)
            begin
                phase_next = hcbd_pkg::PH_ERROR;
            end
            else
            begin
                left_next  = cur_chunk + SIZE_W'(2);
                phase_next = hcbd_pkg::PH_DATA;
            end
        end
        else
        begin
            case (cur_phase)
                hcbd_pkg::PH_BLANK,
                hcbd_pkg::PH_SIGN:
                begin
                    if (cur_phase == hcbd_pkg::PH_BLANK && is_blank)
                    begin
                        phase_next = hcbd_pkg::PH_BLANK;
                    end
                    else if (cur_phase == hcbd_pkg::PH_BLANK &&
                             (c == hcbd_pkg::CHAR_PLUS || c == hcbd_pkg::CHAR_MINUS))
                    begin
                        neg_next   = (c == hcbd_pkg::CHAR_MINUS);
                        phase_next = hcbd_pkg::PH_SIGN;
                    end
                    else if (hex_ok && hex_digit == 4'd0)
                    begin
                        phase_next = hcbd_pkg::PH_ZERO;
                    end
                    else if (hex_ok)
                    begin
                        chunk_next = chunk_added;
                        phase_next = hcbd_pkg::PH_DIGITS;
                    end
                    else
                    begin
                        phase_next = hcbd_pkg::PH_REST;
                    end
                end
                hcbd_pkg::PH_ZERO,
                hcbd_pkg::PH_DIGITS:
                begin
                    if (cur_phase == hcbd_pkg::PH_ZERO && is_x)
                    begin
                        phase_next = hcbd_pkg::PH_DIGITS;
                    end
                    else if (hex_ok)
                    begin
                        chunk_next = chunk_added;
                        phase_next = hcbd_pkg::PH_DIGITS;
                    end
                    else
                    begin
                        phase_next = hcbd_pkg::PH_REST;
                    end
                end
                hcbd_pkg::PH_DATA:
                begin
                    count_next = cur_count + LENGTH_BITS'(1);
                    left_next  = left_dec;
                    if (left_dec <= SIZE_W'(2))
                    begin
                        phase_next = hcbd_pkg::PH_CRLF;
                    end
                end
                hcbd_pkg::PH_CRLF:
                begin
                    if (cur_left != '0)
                    begin
                        left_next = left_dec;
                    end
                    if (cur_left <= SIZE_W'(1))
                    begin
                        phase_next = hcbd_pkg::PH_BLANK;
                        chunk_next = '0;
                        neg_next   = 1'b0;
                    end
                end
                hcbd_pkg::PH_TRAILER:
                begin
                    if (is_lf)
                    begin
                        if (cur_tlen < hcbd_pkg::TLEN_LONG)
                        begin
                            phase_next = hcbd_pkg::PH_DONE;
                        end
                        else
                        begin
                            tlen_next = hcbd_pkg::TLEN_EMPTY;
                        end
                    end
                    else if (cur_tlen == hcbd_pkg::TLEN_EMPTY && c == hcbd_pkg::CHAR_CR)
                    begin
                        tlen_next = hcbd_pkg::TLEN_CR;
                    end
                    else
                    begin
                        tlen_next = hcbd_pkg::TLEN_LONG;
                    end
                end
                default:
                begin
                    phase_next = cur_phase;
                end
            endcase
        end
    end

    // Result of this byte.
    always_comb
    begin
        emit      = 1'b0;
        emit_kind = hcbd_pkg::KIND_PAYLOAD;
        emit_code = hcbd_pkg::ERR_NONE;
        emit_byte = '0;
        case (cur_phase)
            hcbd_pkg::PH_BLANK,
            hcbd_pkg::PH_SIGN,
            hcbd_pkg::PH_ZERO,
            hcbd_pkg::PH_DIGITS,
            hcbd_pkg::PH_REST:
            begin
                if (is_lf && neg_error)
                begin
                    emit      = 1'b1;
                    emit_kind = hcbd_pkg::KIND_ERROR;
                    emit_code = hcbd_pkg::ERR_NEGATIVE;
                end
                else if (is_lf && !size_zero && over_limit)
                begin
                    emit      = 1'b1;
                    emit_kind = hcbd_pkg::KIND_ERROR;
                    emit_code = hcbd_pkg::ERR_TOO_BIG;
                end
            end
            hcbd_pkg::PH_DATA:
            begin
                emit      = 1'b1;
                emit_byte = c;
            end
            hcbd_pkg::PH_TRAILER:
            begin
                if (is_lf && cur_tlen < hcbd_pkg::TLEN_LONG)
                begin
                    emit      = 1'b1;
                    emit_kind = hcbd_pkg::KIND_COMPLETE;
                end
            end
            default:
            begin
                emit = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            body_limit_reg <= hcbd_pkg::BODY_LIMIT_RESET;
        end
        else if (cfg_write_en)
        begin
            body_limit_reg <= cfg_write_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_chan.ready)
        begin
            in_valid_reg <= in_chan.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_chan.ready && in_chan.valid)
        begin
            data_reg  <= in_chan.data_byte;
            first_reg <= in_chan.first_byte;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= hcbd_pkg::PH_IDLE;
            chunk_reg <= '0;
            left_reg  <= '0;
            count_reg <= '0;
            neg_reg   <= 1'b0;
            tlen_reg  <= hcbd_pkg::TLEN_EMPTY;
        end
        else if (advance)
        begin
            phase_reg <= phase_next;
            chunk_reg <= chunk_next;
            left_reg  <= left_next;
            count_reg <= count_next;
            neg_reg   <= neg_next;
            tlen_reg  <= tlen_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            res_valid_reg <= emit;
        end
        else if (out_chan.ready)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && emit)
        begin
            kind_reg    <= emit_kind;
            payload_reg <= emit_byte;
            length_reg  <= hcbd_pkg::LENGTH_W'(count_next);
            code_reg    <= emit_code;
        end
    end

    assign out_chan.valid        = res_valid_reg;
    assign out_chan.kind         = kind_reg;
    assign out_chan.payload_byte = payload_reg;
    assign out_chan.decoded_len  = length_reg;
    assign out_chan.error_code   = code_reg;

endmodule
